### rtl/llfp_pkg.sv
// Shared constants, types and helpers for the linked list free pool engine.
package llfp_pkg;

	localparam int SLOTS   = 32;
	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int LINK_W  = SLOT_W + 1;
	localparam int CNT_W   = $clog2(SLOTS + 1);
	localparam int MAX_RES = 32;
	localparam int CMD_W   = 4;
	localparam int IDX_W   = 8;
	localparam int KEY_W   = 32;
	localparam int PAY_W   = 64;
	localparam int ST_W    = 3;
	localparam int OSLOT_W = 5;

	// link MSB set means null
	localparam logic [LINK_W-1:0] NIL_LINK = {1'b1, {SLOT_W{1'b0}}};

	typedef enum logic [CMD_W-1:0] {
		CMD_INS_FIRST = 4'd0,
		CMD_INS_LAST  = 4'd1,
		CMD_INS_POS   = 4'd2,
		CMD_DEL_FIRST = 4'd3,
		CMD_DEL_LAST  = 4'd4,
		CMD_DEL_POS   = 4'd5,
		CMD_DEL_KEY   = 4'd6,
		CMD_FIND      = 4'd7,
		CMD_WALK      = 4'd8
	} cmd_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK        = 3'd0,
		ST_POOL_FULL = 3'd1,
		ST_EMPTY     = 3'd2,
		ST_BAD_POS   = 3'd3,
		ST_NOT_FOUND = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHK,
		S_RD,
		S_EV,
		S_ALLOC_RD,
		S_ALLOC_WR,
		S_LINK,
		S_DEL_RD,
		S_DEL_LINK,
		S_DEL_FREE,
		S_OUT
	} state_t;

	typedef struct packed {
		logic              re;
		logic [SLOT_W-1:0] raddr;
		logic              we_next;
		logic              we_data;
		logic [SLOT_W-1:0] waddr;
		logic [LINK_W-1:0] wnext;
		logic [KEY_W-1:0]  wkey;
		logic [PAY_W-1:0]  wpay;
	} mem_req_t;

	typedef struct packed {
		logic [LINK_W-1:0] next;
		logic [KEY_W-1:0]  key;
		logic [PAY_W-1:0]  pay;
	} mem_rsp_t;

	// link held by a slot after reset: slot i points at i-1, slot 0 at null
	function automatic logic [LINK_W-1:0] reset_link(input logic [SLOT_W-1:0] s);
		logic [LINK_W-1:0] r;
		if (s == '0) begin
			r = NIL_LINK;
		end else begin
			r = {1'b0, s - 1'b1};
		end
		return r;
	endfunction

endpackage

### rtl/llfp_cmd_if.sv
// Command channel: valid/ready plus one command beat.
interface llfp_cmd_if;
	import llfp_pkg::*;

	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] cmd;
	logic [IDX_W-1:0] index;
	logic [KEY_W-1:0] key;
	logic [PAY_W-1:0] payload;

	modport source(output valid, output cmd, output index, output key, output payload,
		input ready);
	modport sink(input valid, input cmd, input index, input key, input payload,
		output ready);
endinterface

### rtl/llfp_res_if.sv
// Result channel: valid/ready plus one result beat.
interface llfp_res_if;
	import llfp_pkg::*;

	logic               valid;
	logic               ready;
	logic [ST_W-1:0]    status;
	logic               found;
	logic [OSLOT_W-1:0] slot;
	logic [OSLOT_W-1:0] position;
	logic [KEY_W-1:0]   out_key;
	logic [PAY_W-1:0]   out_payload;
	logic               last;
	logic               list_empty;
	logic               pool_full;

	modport source(output valid, output status, output found, output slot, output position,
		output out_key, output out_payload, output last, output list_empty,
		output pool_full, input ready);
	modport sink(input valid, input status, input found, input slot, input position,
		input out_key, input out_payload, input last, input list_empty,
		input pool_full, output ready);
endinterface

### rtl/linked_list_free_pool_engine_top.sv
// Result beat after an insert-at-front beat: check, allocate-read, allocate-write;
// after delete-first: check, delete-read, unlink, free. Linking the new slot behind an
// entry adds a link write; a list walk adds a read and an evaluate state per link read,
// plus a read check that ends it on null or at the target position. Walk gives one
// result beat per entry. One command in flight; the next can be taken in the cycle
// after the last result beat is accepted. Reset: list empty, free chain from the highest
// slot down; links read reset values via per-slot valid bits, so no clearing pass is needed.
module linked_list_free_pool_engine_top (
	input  logic       clk,
	input  logic       arst_n,
	llfp_cmd_if.sink   req,
	llfp_res_if.source rsp
);
	import llfp_pkg::*;

	// request/response between sequencer and slot memories
	mem_req_t mreq;
	mem_rsp_t mrsp;

	// sequencer: owns head and free-head registers and the result register
	llfp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.mreq   (mreq),
		.mrsp   (mrsp)
	);

	// slot memories, registered read; accesses are strictly serialized
	llfp_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);
endmodule

### rtl/llfp_mem.sv
// Slot storage: link memory with reset-valid bits, and key/payload memory.
module llfp_mem (
	input  logic              clk,
	input  logic              arst_n,
	input  llfp_pkg::mem_req_t req,
	output llfp_pkg::mem_rsp_t rsp
);
	import llfp_pkg::*;

	logic [LINK_W-1:0]      next_mem [SLOTS];
	logic [KEY_W+PAY_W-1:0] data_mem [SLOTS];
	logic [SLOTS-1:0]       nv_q;
	logic [LINK_W-1:0]      next_raw_q;
	logic                   nv_rd_q;
	logic [SLOT_W-1:0]      raddr_q;
	logic [KEY_W+PAY_W-1:0] data_q;

	// link written since reset; otherwise it reads the reset pattern
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nv_q <= '0;
		end else if (req.we_next) begin
			nv_q[req.waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.we_next) begin
			next_mem[req.waddr] <= req.wnext;
		end
		if (req.we_data) begin
			data_mem[req.waddr] <= {req.wkey, req.wpay};
		end
		if (req.re) begin
			next_raw_q <= next_mem[req.raddr];
			data_q     <= data_mem[req.raddr];
			nv_rd_q    <= nv_q[req.raddr];
			raddr_q    <= req.raddr;
		end
	end

	assign rsp.next = nv_rd_q ? next_raw_q : reset_link(raddr_q);
	assign rsp.key  = data_q[KEY_W+PAY_W-1:PAY_W];
	assign rsp.pay  = data_q[PAY_W-1:0];
endmodule

### rtl/llfp_ctrl.sv
// Command sequencer: list walks, slot allocation and release, result register.
module llfp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	llfp_cmd_if.sink           req,
	llfp_res_if.source         rsp,
	output llfp_pkg::mem_req_t mreq,
	input  llfp_pkg::mem_rsp_t mrsp
);
	import llfp_pkg::*;

	state_t             state_q, state_d;
	logic [CMD_W-1:0]   cmd_q;
	logic [IDX_W-1:0]   idx_q;
	logic [KEY_W-1:0]   key_q;
	logic [PAY_W-1:0]   pay_q;
	logic [LINK_W-1:0]  head_q, free_q, prev_q, cur_q;
	logic [CNT_W-1:0]   i_q;
	status_t            rst_q;
	logic               rfound_q, rlast_q;
	logic [SLOT_W-1:0]  rslot_q;
	logic [CNT_W-1:0]   rpos_q;
	logic [KEY_W-1:0]   rkey_q;
	logic [PAY_W-1:0]   rpay_q;

	logic is_ins, is_del, at_idx, cur_nil, free_nil, head_nil, prev_nil;
	logic nx_nil, key_hit, rd_done, ev_adv, walk_last, beat_out;

	assign is_ins   = (cmd_q == CMD_INS_FIRST) || (cmd_q == CMD_INS_LAST) ||
		(cmd_q == CMD_INS_POS);
	assign is_del   = (cmd_q == CMD_DEL_FIRST) || (cmd_q == CMD_DEL_LAST) ||
		(cmd_q == CMD_DEL_POS) || (cmd_q == CMD_DEL_KEY);
	assign at_idx   = (IDX_W'(i_q) == idx_q);
	assign cur_nil  = cur_q[SLOT_W];
	assign free_nil = free_q[SLOT_W];
	assign head_nil = head_q[SLOT_W];
	assign prev_nil = prev_q[SLOT_W];
	assign nx_nil   = mrsp.next[SLOT_W];
	assign key_hit  = (mrsp.key == key_q);
	assign rd_done  = cur_nil ||
		(((cmd_q == CMD_INS_POS) || (cmd_q == CMD_DEL_POS)) && at_idx);
	assign ev_adv   = (cmd_q == CMD_INS_LAST) || (cmd_q == CMD_INS_POS) ||
		(cmd_q == CMD_DEL_POS) || ((cmd_q == CMD_DEL_LAST) && !nx_nil) ||
		(((cmd_q == CMD_DEL_KEY) || (cmd_q == CMD_FIND)) && !key_hit);
	assign walk_last = nx_nil || (i_q == CNT_W'(MAX_RES - 1));
	assign beat_out = rsp.valid && rsp.ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req.valid) state_d = S_CHK;
			end
			S_CHK: begin
				if (is_ins) begin
					if (free_nil) state_d = S_OUT;
					else if (cmd_q == CMD_INS_FIRST) state_d = S_ALLOC_RD;
					else state_d = S_RD;
				end else if (is_del) begin
					if (head_nil) state_d = S_OUT;
					else if (cmd_q == CMD_DEL_FIRST) state_d = S_DEL_RD;
					else state_d = S_RD;
				end else if (cmd_q == CMD_FIND) begin
					state_d = S_RD;
				end else if (cmd_q == CMD_WALK) begin
					state_d = cur_nil ? S_OUT : S_RD;
				end else begin
					state_d = S_OUT;
				end
			end
			S_RD: begin
				if (!rd_done) begin
					state_d = S_EV;
				end else begin
					case (cmd_q)
						CMD_INS_LAST: state_d = S_ALLOC_RD;
						CMD_INS_POS:  state_d = at_idx ? S_ALLOC_RD : S_OUT;
						CMD_DEL_POS:  state_d = (at_idx && !cur_nil) ? S_DEL_RD : S_OUT;
						default:      state_d = S_OUT;
					endcase
				end
			end
			S_EV: begin
				if (ev_adv) state_d = S_RD;
				else if (cmd_q == CMD_FIND || cmd_q == CMD_WALK) state_d = S_OUT;
				else state_d = S_DEL_RD;
			end
			S_ALLOC_RD: state_d = S_ALLOC_WR;
			S_ALLOC_WR: state_d = prev_nil ? S_OUT : S_LINK;
			S_LINK:     state_d = S_OUT;
			S_DEL_RD:   state_d = S_DEL_LINK;
			S_DEL_LINK: state_d = S_DEL_FREE;
			S_DEL_FREE: state_d = S_OUT;
			S_OUT: begin
				if (beat_out) begin
					state_d = (cmd_q == CMD_WALK && !rlast_q) ? S_RD : S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs: handshakes and memory requests
	always_comb begin
		mreq         = '0;
		mreq.wkey    = key_q;
		mreq.wpay    = pay_q;
		req.ready    = (state_q == S_IDLE);
		rsp.valid    = (state_q == S_OUT);
		case (state_q)
			S_RD: begin
				mreq.re    = !rd_done;
				mreq.raddr = cur_q[SLOT_W-1:0];
			end
			S_ALLOC_RD: begin
				mreq.re    = 1'b1;
				mreq.raddr = free_q[SLOT_W-1:0];
			end
			S_ALLOC_WR: begin
				mreq.we_next = 1'b1;
				mreq.we_data = 1'b1;
				mreq.waddr   = free_q[SLOT_W-1:0];
				mreq.wnext   = cur_q;
			end
			S_LINK: begin
				mreq.we_next = 1'b1;
				mreq.waddr   = prev_q[SLOT_W-1:0];
				mreq.wnext   = {1'b0, rslot_q};
			end
			S_DEL_RD: begin
				mreq.re    = 1'b1;
				mreq.raddr = cur_q[SLOT_W-1:0];
			end
			S_DEL_LINK: begin
				mreq.we_next = !prev_nil;
				mreq.waddr   = prev_q[SLOT_W-1:0];
				mreq.wnext   = mrsp.next;
			end
			S_DEL_FREE: begin
				mreq.we_next = 1'b1;
				mreq.waddr   = cur_q[SLOT_W-1:0];
				mreq.wnext   = free_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= NIL_LINK;
			free_q  <= {1'b0, SLOT_W'(SLOTS - 1)};
		end else begin
			state_q <= state_d;
			if (state_q == S_ALLOC_WR) begin
				free_q <= mrsp.next;
				if (prev_nil) head_q <= free_q;
			end
			if (state_q == S_LINK && prev_nil) head_q <= {1'b0, rslot_q};
			if (state_q == S_DEL_LINK && prev_nil) head_q <= mrsp.next;
			if (state_q == S_DEL_FREE) free_q <= cur_q;
		end
	end

	// command and result registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cmd_q    <= req.cmd;
				idx_q    <= req.index;
				key_q    <= req.key;
				pay_q    <= req.payload;
				cur_q    <= head_q;
				prev_q   <= NIL_LINK;
				i_q      <= '0;
				rst_q    <= ST_OK;
				rfound_q <= 1'b0;
				rslot_q  <= '0;
				rpos_q   <= '0;
				rkey_q   <= '0;
				rpay_q   <= '0;
				rlast_q  <= 1'b1;
			end
			S_CHK: begin
				if (is_ins && free_nil) rst_q <= ST_POOL_FULL;
				else if (is_del && head_nil) rst_q <= ST_EMPTY;
				else if (cmd_q == CMD_WALK && cur_nil) rst_q <= ST_EMPTY;
			end
			S_RD: begin
				if (rd_done) begin
					case (cmd_q)
						CMD_INS_POS: if (!at_idx) rst_q <= ST_BAD_POS;
						CMD_DEL_POS: if (!at_idx || cur_nil) rst_q <= ST_BAD_POS;
						CMD_DEL_KEY, CMD_FIND: rst_q <= ST_NOT_FOUND;
						default: ;
					endcase
				end
			end
			S_EV: begin
				if (ev_adv) begin
					prev_q <= cur_q;
					cur_q  <= mrsp.next;
					i_q    <= i_q + 1'b1;
				end else if (cmd_q == CMD_FIND) begin
					rfound_q <= 1'b1;
					rslot_q  <= cur_q[SLOT_W-1:0];
				end else if (cmd_q == CMD_WALK) begin
					rslot_q <= cur_q[SLOT_W-1:0];
					rpos_q  <= i_q;
					rkey_q  <= mrsp.key;
					rpay_q  <= mrsp.pay;
					rlast_q <= walk_last;
					cur_q   <= mrsp.next;
				end
			end
			S_ALLOC_WR: rslot_q <= free_q[SLOT_W-1:0];
			S_DEL_FREE: begin
				rslot_q  <= cur_q[SLOT_W-1:0];
				rfound_q <= (cmd_q == CMD_DEL_KEY);
			end
			S_OUT: begin
				if (beat_out) i_q <= i_q + 1'b1;
			end
			default: ;
		endcase
	end

	assign rsp.status      = rst_q;
	assign rsp.found       = rfound_q;
	assign rsp.slot        = OSLOT_W'(rslot_q);
	assign rsp.position    = OSLOT_W'(rpos_q);
	assign rsp.out_key     = rkey_q;
	assign rsp.out_payload = rpay_q;
	assign rsp.last        = rlast_q;
	assign rsp.list_empty  = head_nil;
	assign rsp.pool_full   = free_nil;
endmodule

### rtl/llfp_checker.sv
// Port-level checks for the engine, bound to the top level.
module llfp_checker (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    req_ready,
	input logic                    rsp_valid,
	input logic                    rsp_ready,
	input logic [llfp_pkg::ST_W-1:0] rsp_status,
	input logic                    rsp_found,
	input logic                    rsp_last,
	input logic                    rsp_list_empty,
	input logic                    rsp_pool_full
);
	import llfp_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result beat dropped while stalled");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		!(req_ready && rsp_valid))
		else $error("command taken while result pending");

	a_state: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_list_empty && rsp_pool_full))
		else $error("list empty and pool full together");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != ST_OK) |-> rsp_last && !rsp_found)
		else $error("error result not final or marked found");
endmodule

bind linked_list_free_pool_engine_top llfp_checker u_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_status     (rsp.status),
	.rsp_found      (rsp.found),
	.rsp_last       (rsp.last),
	.rsp_list_empty (rsp.list_empty),
	.rsp_pool_full  (rsp.pool_full)
);

### dv/linked_list_free_pool_engine_top_tb.sv
// Self-checking testbench for the linked list free pool engine: directed table, pool fill, then random.
module linked_list_free_pool_engine_top_tb;
	import llfp_pkg::*;

	localparam int NULL_SLOT = -1;
	localparam int IDLE_LIMIT = 20000;
	localparam int N_ROWS = 24;

	// one expected result beat
	typedef struct {
		status_t          status;
		logic             found;
		logic [4:0]       slot;
		logic [4:0]       position;
		logic [KEY_W-1:0] out_key;
		logic [PAY_W-1:0] out_payload;
		logic             last;
		logic             list_empty;
		logic             pool_full;
	} beat_t;

	// directed row: command plus optional typed-in status for the single beat
	typedef struct {
		logic [CMD_W-1:0] cmd;
		logic [IDX_W-1:0] index;
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
		bit               has_status;
		status_t          status;
	} row_t;

	logic clk;
	logic arst_n;
	llfp_cmd_if req();
	llfp_res_if rsp();

	linked_list_free_pool_engine_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	// shadow of the pool: links as ints, -1 = null
	logic [KEY_W-1:0] pool_key[SLOTS];
	logic [PAY_W-1:0] pool_pay[SLOTS];
	int               pool_next[SLOTS];
	int               list_head;
	int               free_head;
	int               list_len;

	beat_t pending_beats[$];
	int    errors;
	int    idle_cycles;
	bit    stim_done;
	bit    hold_off;
	bit    row_check;
	status_t row_status;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic beat_t make_beat(status_t st, logic fnd, int s, int pos,
			logic [KEY_W-1:0] k, logic [PAY_W-1:0] p, logic lst);
		beat_t b;
		b.status = st;
		b.found = fnd;
		b.slot = s[4:0];
		b.position = pos[4:0];
		b.out_key = k;
		b.out_payload = p;
		b.last = lst;
		b.list_empty = (list_head == NULL_SLOT);
		b.pool_full = (free_head == NULL_SLOT);
		return b;
	endfunction

	// apply one command to the shadow pool and queue its result beats
	task automatic predict_list_op(logic [CMD_W-1:0] c, int idx, logic [KEY_W-1:0] k,
			logic [PAY_W-1:0] p);
		int prev;
		int cur;
		int i;
		int s;
		int n;
		int nx;
		prev = NULL_SLOT;
		cur = list_head;
		i = 0;
		case (c)
			CMD_INS_FIRST, CMD_INS_LAST, CMD_INS_POS: begin
				if (free_head == NULL_SLOT) begin
					pending_beats.push_back(make_beat(ST_POOL_FULL, 0, 0, 0, 0, 0, 1));
					return;
				end
				if (c == CMD_INS_LAST) begin
					while (cur != NULL_SLOT) begin
						prev = cur; cur = pool_next[cur]; i++;
					end
				end else if (c == CMD_INS_POS) begin
					while (cur != NULL_SLOT && i < idx) begin
						prev = cur; cur = pool_next[cur]; i++;
					end
					if (i != idx) begin
						pending_beats.push_back(make_beat(ST_BAD_POS, 0, 0, 0, 0, 0, 1));
						return;
					end
				end
				s = free_head;
				free_head = pool_next[s];
				pool_key[s] = k;
				pool_pay[s] = p;
				pool_next[s] = cur;
				if (prev == NULL_SLOT) list_head = s; else pool_next[prev] = s;
				list_len++;
				pending_beats.push_back(make_beat(ST_OK, 0, s, 0, 0, 0, 1));
			end
			CMD_DEL_FIRST, CMD_DEL_LAST, CMD_DEL_POS, CMD_DEL_KEY: begin
				if (list_head == NULL_SLOT) begin
					pending_beats.push_back(make_beat(ST_EMPTY, 0, 0, 0, 0, 0, 1));
					return;
				end
				if (c == CMD_DEL_LAST) begin
					while (pool_next[cur] != NULL_SLOT) begin
						prev = cur; cur = pool_next[cur];
					end
				end else if (c == CMD_DEL_POS) begin
					while (cur != NULL_SLOT && i < idx) begin
						prev = cur; cur = pool_next[cur]; i++;
					end
					if (i != idx || cur == NULL_SLOT) begin
						pending_beats.push_back(make_beat(ST_BAD_POS, 0, 0, 0, 0, 0, 1));
						return;
					end
				end else if (c == CMD_DEL_KEY) begin
					while (cur != NULL_SLOT && pool_key[cur] != k) begin
						prev = cur; cur = pool_next[cur];
					end
					if (cur == NULL_SLOT) begin
						pending_beats.push_back(make_beat(ST_NOT_FOUND, 0, 0, 0, 0, 0, 1));
						return;
					end
				end
				if (prev == NULL_SLOT) list_head = pool_next[cur];
				else pool_next[prev] = pool_next[cur];
				pool_next[cur] = free_head;
				free_head = cur;
				list_len--;
				pending_beats.push_back(make_beat(ST_OK, c == CMD_DEL_KEY, cur, 0, 0, 0, 1));
			end
			CMD_FIND: begin
				while (cur != NULL_SLOT && pool_key[cur] != k) cur = pool_next[cur];
				if (cur == NULL_SLOT)
					pending_beats.push_back(make_beat(ST_NOT_FOUND, 0, 0, 0, 0, 0, 1));
				else
					pending_beats.push_back(make_beat(ST_OK, 1, cur, 0, 0, 0, 1));
			end
			CMD_WALK: begin
				if (cur == NULL_SLOT) begin
					pending_beats.push_back(make_beat(ST_EMPTY, 0, 0, 0, 0, 0, 1));
					return;
				end
				n = 0;
				while (cur != NULL_SLOT && n < MAX_RES) begin
					nx = pool_next[cur];
					pending_beats.push_back(make_beat(ST_OK, 0, cur, n, pool_key[cur],
						pool_pay[cur], nx == NULL_SLOT || n == MAX_RES - 1));
					n++;
					cur = nx;
				end
			end
			default: pending_beats.push_back(make_beat(ST_OK, 0, 0, 0, 0, 0, 1));
		endcase
	endtask

	// pick a key that is probably in the list, to hit find / del_key matches
	function automatic logic [KEY_W-1:0] live_key();
		int cur;
		int hops;
		cur = list_head;
		if (cur == NULL_SLOT || $urandom_range(3) == 0) return $urandom;
		hops = $urandom_range(list_len - 1);
		repeat (hops) cur = pool_next[cur];
		return pool_key[cur];
	endfunction

	// drive one beat; returns after it is accepted, with bursty gaps before it
	task automatic send_cmd(logic [CMD_W-1:0] c, logic [IDX_W-1:0] idx,
			logic [KEY_W-1:0] k, logic [PAY_W-1:0] p);
		if ($urandom_range(3) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.cmd <= c;
		req.index <= idx;
		req.key <= k;
		req.payload <= p;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		predict_list_op(c, idx, k, p);
		// typed-in status of a directed row
		if (row_check && pending_beats[$].status != row_status) begin
			$display("%0t: directed status expected %0d got prediction %0d", $time,
				row_status, pending_beats[$].status);
			errors++;
		end
	endtask

	// directed table: extremes, every command, every error case but pool full
	row_t dir_rows[N_ROWS] = '{
		'{CMD_WALK,      8'd0,   32'h0,        64'h0,                 1, ST_EMPTY},
		'{CMD_DEL_FIRST, 8'd0,   32'h0,        64'h0,                 1, ST_EMPTY},
		'{CMD_DEL_LAST,  8'd0,   32'h0,        64'h0,                 1, ST_EMPTY},
		'{CMD_DEL_POS,   8'd0,   32'h0,        64'h0,                 1, ST_EMPTY},
		'{CMD_DEL_KEY,   8'd0,   32'h5,        64'h0,                 1, ST_EMPTY},
		'{CMD_FIND,      8'd0,   32'h5,        64'h0,                 1, ST_NOT_FOUND},
		'{CMD_INS_POS,   8'd1,   32'h1,        64'h1,                 1, ST_BAD_POS},
		'{CMD_INS_FIRST, 8'd0,   32'hFFFFFFFF, 64'hFFFFFFFFFFFFFFFF,  1, ST_OK},
		'{CMD_INS_LAST,  8'd255, 32'h0,        64'h0,                 1, ST_OK},
		'{CMD_INS_POS,   8'd2,   32'hA5A5A5A5, 64'h5A5A5A5A5A5A5A5A,  1, ST_OK},
		'{CMD_INS_POS,   8'd1,   32'h12345678, 64'h0123456789ABCDEF,  1, ST_OK},
		'{CMD_INS_POS,   8'd255, 32'h1,        64'h1,                 1, ST_BAD_POS},
		'{CMD_WALK,      8'd0,   32'h0,        64'h0,                 0, ST_OK},
		'{CMD_FIND,      8'd0,   32'hA5A5A5A5, 64'h0,                 1, ST_OK},
		'{CMD_FIND,      8'd0,   32'hDEADBEEF, 64'h0,                 1, ST_NOT_FOUND},
		'{CMD_DEL_POS,   8'd4,   32'h0,        64'h0,                 1, ST_BAD_POS},
		'{CMD_DEL_POS,   8'd255, 32'h0,        64'h0,                 1, ST_BAD_POS},
		'{CMD_DEL_KEY,   8'd0,   32'hDEADBEEF, 64'h0,                 1, ST_NOT_FOUND},
		'{CMD_DEL_KEY,   8'd0,   32'h12345678, 64'h0,                 1, ST_OK},
		'{CMD_DEL_POS,   8'd1,   32'h0,        64'h0,                 1, ST_OK},
		'{CMD_DEL_LAST,  8'd0,   32'h0,        64'h0,                 1, ST_OK},
		'{CMD_DEL_FIRST, 8'd0,   32'h0,        64'h0,                 1, ST_OK},
		'{4'd9,          8'd0,   32'h0,        64'h0,                 1, ST_OK},
		'{4'd15,         8'hFF,  32'hFFFFFFFF, 64'hFFFFFFFFFFFFFFFF,  1, ST_OK}
	};

	// sender: reset, directed rows, pool fill/overflow, then random traffic
	initial begin
		int r;
		int op;
		logic [CMD_W-1:0] c;
		logic [IDX_W-1:0] idx;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.cmd = '0;
		req.index = '0;
		req.key = '0;
		req.payload = '0;
		errors = 0;
		stim_done = 0;
		row_check = 0;
		list_head = NULL_SLOT;
		free_head = SLOTS - 1;
		list_len = 0;
		for (int i = 0; i < SLOTS; i++) pool_next[i] = i - 1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			row_check = dir_rows[i].has_status;
			row_status = dir_rows[i].status;
			send_cmd(dir_rows[i].cmd, dir_rows[i].index, dir_rows[i].key,
				dir_rows[i].payload);
		end
		row_check = 0;

		// fill the pool past full, walk the full list (32 beats), then drain to four entries
		repeat (SLOTS + 2) send_cmd(CMD_INS_LAST, IDX_W'($urandom), $urandom,
			{$urandom, $urandom});
		send_cmd(CMD_INS_POS, 8'd0, 32'h1, 64'h1);
		send_cmd(CMD_WALK, 8'd0, 32'h0, 64'h0);
		send_cmd(CMD_DEL_POS, IDX_W'(SLOTS - 1), 32'h0, 64'h0);
		send_cmd(CMD_INS_POS, IDX_W'(SLOTS - 1), $urandom, {$urandom, $urandom});
		repeat (SLOTS - 4) send_cmd(CMD_DEL_FIRST, 8'd0, 32'h0, 64'h0);

		// random: inserts and deletes kept around 24 entries, plus finds, key deletes, walks, bad commands
		for (int n = 0; n < 240; n++) begin
			r = $urandom_range(99);
			if (r < 40) begin
				op = (list_len > 24) ? $urandom_range(3, 6) : $urandom_range(0, 2);
				if ($urandom_range(1)) op = $urandom_range(0, 6);
			end else if (r < 55) op = CMD_FIND;
			else if (r < 70) op = CMD_DEL_KEY;
			else if (r < 85) op = CMD_WALK;
			else if (r < 95) op = $urandom_range(0, 6);
			else op = $urandom_range(9, 15);
			c = CMD_W'(op);
			// positions mostly in range, sometimes just past or wild
			case ($urandom_range(9))
				0: idx = IDX_W'($urandom);
				1: idx = IDX_W'(list_len + 1);
				2: idx = IDX_W'(list_len);
				default: idx = IDX_W'($urandom_range(list_len));
			endcase
			send_cmd(c, idx, (c == CMD_FIND || c == CMD_DEL_KEY) ? live_key() : $urandom,
				{$urandom, $urandom});
		end
		req.valid <= 1'b0;
		stim_done = 1;
	end

	// receiver stall pattern, plus one long hold-off while commands keep coming
	initial begin
		rsp.ready = 1'b0;
		hold_off = 0;
		@(posedge arst_n);
		fork
			begin
				repeat (400) @(posedge clk);
				hold_off = 1;
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
		join_none
		forever begin
			@(posedge clk);
			if (hold_off) rsp.ready <= 1'b0;
			else if (($time / 2000) % 3 == 0) rsp.ready <= 1'b1;
			else rsp.ready <= ($urandom_range(3) != 0);
		end
	end

	// compare accepted result beats against the oldest expectation
	always @(posedge clk) begin
		beat_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_beats.size() == 0) begin
				$display("%0t: unexpected result beat status=%0d slot=%0d", $time,
					rsp.status, rsp.slot);
				errors++;
			end else begin
				e = pending_beats.pop_front();
				if (rsp.status !== e.status || rsp.found !== e.found || rsp.slot !== e.slot ||
						rsp.position !== e.position || rsp.out_key !== e.out_key ||
						rsp.out_payload !== e.out_payload || rsp.last !== e.last ||
						rsp.list_empty !== e.list_empty || rsp.pool_full !== e.pool_full) begin
					$display("%0t: exp st=%0d f=%0b sl=%0d pos=%0d k=%h p=%h l=%0b e=%0b fu=%0b",
						$time, e.status, e.found, e.slot, e.position, e.out_key,
						e.out_payload, e.last, e.list_empty, e.pool_full);
					$display("%0t: act st=%0d f=%0b sl=%0d pos=%0d k=%h p=%h l=%0b e=%0b fu=%0b",
						$time, rsp.status, rsp.found, rsp.slot, rsp.position, rsp.out_key,
						rsp.out_payload, rsp.last, rsp.list_empty, rsp.pool_full);
					errors++;
				end
			end
		end
	end

	// watchdog on accepted beats; end of test once drained
	initial begin
		idle_cycles = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
			if (stim_done && pending_beats.size() == 0) break;
		end
		repeat (100) @(posedge clk);
		if (errors == 0 && pending_beats.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
